FILE: rtl/nlp_pkg.sv
// Shared constants and types for the next-permutation core.
package nlp_pkg;

  localparam int MAX_LEN = 16;
  localparam int ELEM_W  = 5;
  localparam int LEN_W   = 5;
  localparam int ADDR_W  = $clog2(MAX_LEN);
  localparam int OBUF_DEPTH = 2;
  localparam int OCNT_W  = $clog2(OBUF_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_PSCAN,
    ST_JSCAN,
    ST_EMIT
  } seq_state_e;

  typedef struct packed {
    logic [ELEM_W-1:0] elem;
    logic              last;
    logic              wrapped;
  } res_t;

  typedef struct packed {
    logic valid;
    res_t res;
  } push_t;

  typedef struct packed {
    logic [OCNT_W-1:0] count;
    logic              pop;
  } obuf_stat_t;

endpackage

FILE: rtl/nlp_ram.sv
// Simple dual-port RAM, one write and one registered read port.
module nlp_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 5
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/nlp_obuf.sv
// Two-entry result buffer between the sequencer and the output port.
module nlp_obuf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  nlp_pkg::push_t      push_i,
  output nlp_pkg::obuf_stat_t stat_o,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output nlp_pkg::res_t       res_o
);

  nlp_pkg::res_t                    buf_q [nlp_pkg::OBUF_DEPTH];
  logic [nlp_pkg::OCNT_W-1:0]       count_q, count_d;
  logic                             wr_q, rd_q;
  logic                             pop;

  assign res_valid_o = (count_q != '0);
  assign pop         = res_valid_o & res_ready_i;
  assign res_o       = buf_q[rd_q];

  always_comb begin
    count_d = count_q;
    if (push_i.valid && !pop) begin
      count_d = count_q + nlp_pkg::OCNT_W'(1);
    end else if (!push_i.valid && pop) begin
      count_d = count_q - nlp_pkg::OCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
    end else begin
      count_q <= count_d;
      if (push_i.valid) wr_q <= ~wr_q;
      if (pop)          rd_q <= ~rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      buf_q[wr_q] <= push_i.res;
    end
  end

  assign stat_o.count = count_q;
  assign stat_o.pop   = pop;

endmodule

FILE: rtl/nlp_seq.sv
// Load / pivot scan / swap scan / emit sequencer around the element RAM.
module nlp_seq (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [nlp_pkg::LEN_W-1:0]        n_i,
  input  logic                             in_valid_i,
  input  logic [nlp_pkg::ELEM_W-1:0]       in_elem_i,
  output logic                             in_ready_o,
  output logic                             we_o,
  output logic [nlp_pkg::ADDR_W-1:0]       waddr_o,
  output logic [nlp_pkg::ELEM_W-1:0]       wdata_o,
  output logic                             re_o,
  output logic [nlp_pkg::ADDR_W-1:0]       raddr_o,
  input  logic [nlp_pkg::ELEM_W-1:0]       rdata_i,
  input  nlp_pkg::obuf_stat_t              stat_i,
  output nlp_pkg::push_t                   push_o
);

  localparam int AW = nlp_pkg::ADDR_W;
  localparam int EW = nlp_pkg::ELEM_W;
  localparam int LW = nlp_pkg::LEN_W;

  nlp_pkg::seq_state_e state_q, state_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] scan_q, scan_d;
  logic          sdone_q, sdone_d;
  logic          rv_q, rv_d;
  logic [AW-1:0] ra_q, ra_d;
  logic [EW-1:0] prev_q, prev_d;
  logic [EW-1:0] pv_q, pv_d;
  logic [AW-1:0] piv_q, piv_d;
  logic [AW-1:0] j_q, j_d;
  logic          wrap_q, wrap_d;
  logic [AW-1:0] k_q, k_d;
  logic          ev_q, ev_d;
  logic          elast_q, elast_d;
  logic          eovr_q, eovr_d;
  logic [EW-1:0] eval_q, eval_d;

  logic [AW-1:0] n_last;
  logic [AW-1:0] src;
  logic          issue;
  logic          credit;

  assign n_last = AW'(n_i - LW'(1));
  // mirrored suffix position: k = piv+1 reads the last entry
  assign src    = n_last + piv_q + AW'(1) - k_q;
  assign credit = ({1'b0, stat_i.count} + {2'b00, ev_q})
                  < ({1'b0, nlp_pkg::OCNT_W'(2)} + {2'b00, stat_i.pop});

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    scan_d  = scan_q;
    sdone_d = sdone_q;
    prev_d  = prev_q;
    pv_d    = pv_q;
    piv_d   = piv_q;
    j_d     = j_q;
    wrap_d  = wrap_q;
    k_d     = k_q;
    elast_d = elast_q;
    eovr_d  = eovr_q;
    eval_d  = eval_q;
    ev_d    = 1'b0;
    issue   = 1'b0;
    in_ready_o = 1'b0;
    we_o    = 1'b0;
    waddr_o = cnt_q;
    wdata_o = in_elem_i;
    re_o    = 1'b0;
    raddr_o = scan_q;

    unique case (state_q)
      nlp_pkg::ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          we_o = 1'b1;
          if ((LW'(cnt_q) + LW'(1)) >= n_i) begin
            cnt_d   = '0;
            state_d = nlp_pkg::ST_PSCAN;
            scan_d  = n_last;
            sdone_d = 1'b0;
          end else begin
            cnt_d = cnt_q + AW'(1);
          end
        end
      end

      nlp_pkg::ST_PSCAN: begin
        issue = ~sdone_q;
        if (issue) begin
          if (scan_q == '0) sdone_d = 1'b1;
          else              scan_d  = scan_q - AW'(1);
        end
        if (rv_q) begin
          if (ra_q == n_last) begin
            prev_d = rdata_i;
          end else if (rdata_i < prev_q) begin
            piv_d   = ra_q;
            pv_d    = rdata_i;
            wrap_d  = 1'b0;
            state_d = nlp_pkg::ST_JSCAN;
            scan_d  = n_last;
            sdone_d = 1'b0;
          end else begin
            prev_d = rdata_i;
            if (ra_q == '0) begin
              // no ascent anywhere: wrap to the identity
              wrap_d  = 1'b1;
              k_d     = '0;
              state_d = nlp_pkg::ST_EMIT;
            end
          end
        end
      end

      nlp_pkg::ST_JSCAN: begin
        issue = ~sdone_q;
        if (issue) begin
          if (scan_q == '0) sdone_d = 1'b1;
          else              scan_d  = scan_q - AW'(1);
        end
        if (rv_q && (rdata_i > pv_q)) begin
          j_d     = ra_q;
          k_d     = '0;
          state_d = nlp_pkg::ST_EMIT;
        end
      end

      nlp_pkg::ST_EMIT: begin
        issue = credit;
        if (k_q < piv_q)       raddr_o = k_q;
        else if (k_q == piv_q) raddr_o = j_q;
        else                   raddr_o = src;
        if (issue) begin
          ev_d    = 1'b1;
          elast_d = (k_q == n_last);
          eovr_d  = wrap_q || ((k_q > piv_q) && (src == j_q));
          eval_d  = wrap_q ? (EW'(k_q) + EW'(1)) : pv_q;
          k_d     = k_q + AW'(1);
          if (k_q == n_last) state_d = nlp_pkg::ST_LOAD;
        end
      end

      default: state_d = nlp_pkg::ST_LOAD;
    endcase

    re_o = issue;
    ra_d = raddr_o;
    rv_d = issue && (state_q != nlp_pkg::ST_EMIT) && (state_d == state_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nlp_pkg::ST_LOAD;
      cnt_q   <= '0;
      sdone_q <= 1'b0;
      rv_q    <= 1'b0;
      ev_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      sdone_q <= sdone_d;
      rv_q    <= rv_d;
      ev_q    <= ev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q  <= scan_d;
    ra_q    <= ra_d;
    prev_q  <= prev_d;
    pv_q    <= pv_d;
    piv_q   <= piv_d;
    j_q     <= j_d;
    wrap_q  <= wrap_d;
    k_q     <= k_d;
    elast_q <= elast_d;
    eovr_q  <= eovr_d;
    eval_q  <= eval_d;
  end

  assign push_o.valid       = ev_q;
  assign push_o.res.elem    = eovr_q ? eval_q : rdata_i;
  assign push_o.res.last    = elast_q;
  assign push_o.res.wrapped = wrap_q;

endmodule

FILE: rtl/next_lexicographic_permutation_core.sv
// Sequence: the n-element load, the pivot scan, the swap scan (skipped on a wrap), then the
//   emit reads, whose data pass the RAM read register and the result buffer to the output.
// Loads, scans and emit reads run one after another, the scans and emit reads sharing the
//   single RAM read port; a new load waits for the last emit read and overlaps output drain.
// Results leave through a 2-entry buffer, one per cycle when the consumer is ready.
// Reset (rst_ni low, async): length = 16, load count and buffer cleared; element RAM not cleared.
module next_lexicographic_permutation_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          perm_length_we_i,
  input  logic [nlp_pkg::LEN_W-1:0]     perm_length_i,
  input  logic                          element_valid_i,
  output logic                          element_ready_o,
  input  logic [nlp_pkg::ELEM_W-1:0]    element_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output logic [nlp_pkg::ELEM_W-1:0]    element_res_o,
  output logic                          last_o,
  output logic                          wrapped_o
);

  localparam int LW = nlp_pkg::LEN_W;

  // length register and clamp into 2..MAX_LEN
  logic [LW-1:0] perm_length_q;
  logic [LW-1:0] n_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      perm_length_q <= LW'(16);
    end else if (perm_length_we_i) begin
      perm_length_q <= perm_length_i;
    end
  end

  always_comb begin
    if (perm_length_q < LW'(2))                     n_eff = LW'(2);
    else if (perm_length_q > LW'(nlp_pkg::MAX_LEN)) n_eff = LW'(nlp_pkg::MAX_LEN);
    else                                            n_eff = perm_length_q;
  end

  // element RAM ports
  logic                          we;
  logic [nlp_pkg::ADDR_W-1:0]    waddr;
  logic [nlp_pkg::ELEM_W-1:0]    wdata;
  logic                          re;
  logic [nlp_pkg::ADDR_W-1:0]    raddr;
  logic [nlp_pkg::ELEM_W-1:0]    rdata;

  nlp_pkg::push_t      push;
  nlp_pkg::obuf_stat_t ostat;
  nlp_pkg::res_t       res;

  nlp_ram #(
    .DEPTH (nlp_pkg::MAX_LEN),
    .WIDTH (nlp_pkg::ELEM_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // sequencer: load, find pivot, find swap partner, emit successor
  nlp_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .n_i        (n_eff),
    .in_valid_i (element_valid_i),
    .in_elem_i  (element_i),
    .in_ready_o (element_ready_o),
    .we_o       (we),
    .waddr_o    (waddr),
    .wdata_o    (wdata),
    .re_o       (re),
    .raddr_o    (raddr),
    .rdata_i    (rdata),
    .stat_i     (ostat),
    .push_o     (push)
  );

  // result buffer, decouples emit reads from output backpressure
  nlp_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .stat_o      (ostat),
    .res_valid_o (res_valid_o),
    .res_ready_i (res_ready_i),
    .res_o       (res)
  );

  assign element_res_o = res.elem;
  assign last_o        = res.last;
  assign wrapped_o     = res.wrapped;

  // emit credit must never overfill the buffer
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.valid |-> ((ostat.count != nlp_pkg::OCNT_W'(2)) || ostat.pop))
    else $error("result buffer overflow");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ostat.count <= nlp_pkg::OCNT_W'(2))
    else $error("result buffer count out of range");

  // a request ends with last set; the next one on the port cannot be mid-permutation
  a_last_then_empty_or_new: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.valid && push.res.last) |=> !push.valid)
    else $error("push directly after last element");

endmodule

FILE: tb/next_lexicographic_permutation_core_test.sv
// Self-checking testbench for the next-lexicographic-permutation core.
module next_lexicographic_permutation_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Scoreboard: mirrors the element store and the length register, and
  // queues the successor elements that each completed load must produce.
  class successor_scoreboard;
    logic [nlp_pkg::ELEM_W-1:0] store [nlp_pkg::MAX_LEN];
    int unsigned                fill;
    logic [nlp_pkg::LEN_W-1:0]  length_reg;
    nlp_pkg::res_t              expected_q [$];
    int unsigned                errors;
    int unsigned                perms;
    int unsigned                wraps;
    int unsigned                checked;

    function new();
      fill       = 0;
      length_reg = nlp_pkg::LEN_W'(nlp_pkg::MAX_LEN);
      errors     = 0;
      perms      = 0;
      wraps      = 0;
      checked    = 0;
    endfunction

    // Lengths outside 2..MAX_LEN saturate.
    function int unsigned active_length();
      if (length_reg < 2) return 2;
      if (length_reg > nlp_pkg::MAX_LEN) return nlp_pkg::MAX_LEN;
      return length_reg;
    endfunction

    function void note_request(logic [nlp_pkg::ELEM_W-1:0] e);
      logic [nlp_pkg::ELEM_W-1:0] seq [nlp_pkg::MAX_LEN];
      logic [nlp_pkg::ELEM_W-1:0] t;
      int unsigned                n;
      int                         p;
      int                         j;
      int                         lo;
      int                         hi;
      bit                         wrap;
      nlp_pkg::res_t              r;
      n = active_length();
      if (fill < nlp_pkg::MAX_LEN) store[fill] = e;
      fill++;
      if (fill < n) return;
      // Load complete; a stale count above n still uses only the first n entries.
      fill = 0;
      for (int k = 0; k < n; k++) seq[k] = store[k];
      p = int'(n) - 2;
      while (p >= 0 && !(seq[p] < seq[p+1])) p--;
      wrap = (p < 0);
      if (wrap) begin
        for (int k = 0; k < n; k++) seq[k] = nlp_pkg::ELEM_W'(k + 1);
      end else begin
        j = int'(n) - 1;
        while (seq[j] <= seq[p]) j--;
        t = seq[p];
        seq[p] = seq[j];
        seq[j] = t;
        lo = p + 1;
        hi = int'(n) - 1;
        while (lo < hi) begin
          t = seq[lo];
          seq[lo] = seq[hi];
          seq[hi] = t;
          lo++;
          hi--;
        end
      end
      for (int k = 0; k < n; k++) begin
        r.elem    = seq[k];
        r.last    = (k == n - 1);
        r.wrapped = wrap;
        expected_q = {expected_q, r};
      end
      perms++;
      if (wrap) wraps++;
    endfunction

    function void check_result(logic [nlp_pkg::ELEM_W-1:0] elem, logic last, logic wrapped);
      nlp_pkg::res_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual elem=%0d last=%0b wrapped=%0b",
                 $time, elem, last, wrapped);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (elem !== want.elem) begin
        errors++;
        $display("%0t: elem mismatch: expected %0d, actual %0d", $time, want.elem, elem);
      end
      if (last !== want.last) begin
        errors++;
        $display("%0t: last mismatch: expected %0b, actual %0b", $time, want.last, last);
      end
      if (wrapped !== want.wrapped) begin
        errors++;
        $display("%0t: wrapped mismatch: expected %0b, actual %0b", $time, want.wrapped,
                 wrapped);
      end
    endfunction
  endclass

  localparam int SETTLE_CYCLES = 4 * nlp_pkg::MAX_LEN + 16;  // worst scan/emit latency plus slack
  localparam int HOLD_CYCLES   = 400;                        // long output hold-off
  localparam int TOTAL_ITEMS   = 260;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       perm_length_we_i;
  logic [nlp_pkg::LEN_W-1:0]  perm_length_i;
  logic                       element_valid_i;
  logic                       element_ready_o;
  logic [nlp_pkg::ELEM_W-1:0] element_i;
  logic                       res_valid_o;
  logic                       res_ready_i;
  logic [nlp_pkg::ELEM_W-1:0] element_res_o;
  logic                       last_o;
  logic                       wrapped_o;

  successor_scoreboard book;

  int unsigned                requests;
  int unsigned                burst_left;
  int unsigned                length_writes;
  int unsigned                hold_reqs;
  logic [nlp_pkg::ELEM_W-1:0] perm_buf [nlp_pkg::MAX_LEN];

  next_lexicographic_permutation_core uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .perm_length_we_i (perm_length_we_i),
    .perm_length_i    (perm_length_i),
    .element_valid_i  (element_valid_i),
    .element_ready_o  (element_ready_o),
    .element_i        (element_i),
    .res_valid_o      (res_valid_o),
    .res_ready_i      (res_ready_i),
    .element_res_o    (element_res_o),
    .last_o           (last_o),
    .wrapped_o        (wrapped_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Every accepted result goes straight to the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o && res_ready_i) book.check_result(element_res_o, last_o, wrapped_o);
  end

  // Receiver: stall pattern is redrawn periodically; a requested hold-off
  // keeps ready low long enough for the output buffer and the core to back up.
  initial begin
    int unsigned cyc;
    int unsigned mode;
    int unsigned hold_left;
    int unsigned hold_seen;
    cyc       = 0;
    mode      = 0;
    hold_left = 0;
    hold_seen = 0;
    res_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      cyc++;
      if (cyc % 50 == 0) mode = $urandom_range(0, 3);
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ready_i <= 1'b0;
      end else begin
        case (mode)
          0: res_ready_i <= 1'b1;                          // no stalls
          1: res_ready_i <= 1'($urandom_range(0, 1));      // heavy random stalls
          2: res_ready_i <= ($urandom_range(0, 9) != 0);   // light random stalls
          default: res_ready_i <= ((cyc % 7) < 3);         // periodic on/off
        endcase
      end
    end
  end

  // Offer one element and hold it until the core takes it. The sender runs
  // in bursts; between bursts valid drops for a random gap, sometimes none.
  task automatic send_element(input logic [nlp_pkg::ELEM_W-1:0] e);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk_i);
        element_valid_i <= 1'b0;
      end
    end
    @(negedge clk_i);
    element_valid_i <= 1'b1;
    element_i       <= e;
    do @(posedge clk_i); while (!element_ready_o);
    book.note_request(e);
    requests++;
    burst_left--;
  endtask

  // Length is only changed once all results are in and the core has had
  // time to finish any scan; a partial load may still be pending.
  task automatic write_length(input logic [nlp_pkg::LEN_W-1:0] len);
    @(negedge clk_i);
    element_valid_i <= 1'b0;
    while (book.expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    perm_length_we_i <= 1'b1;
    perm_length_i    <= len;
    @(negedge clk_i);
    perm_length_we_i <= 1'b0;
    book.length_reg = len;
    length_writes++;
  endtask

  // Build one load of n elements: mostly true permutations, plus the
  // first and last permutation, raw 5-bit values and repeated values.
  function automatic void build_perm(input int n);
    int unsigned kind;
    int          j;
    logic [nlp_pkg::ELEM_W-1:0] t;
    kind = $urandom_range(0, 19);
    for (int k = 0; k < n; k++) perm_buf[k] = nlp_pkg::ELEM_W'(k + 1);
    if (kind < 11) begin
      for (int k = n - 1; k > 0; k--) begin
        j = $urandom_range(0, k);
        t = perm_buf[k];
        perm_buf[k] = perm_buf[j];
        perm_buf[j] = t;
      end
    end else if (kind < 13) begin
      for (int k = 0; k < n; k++) perm_buf[k] = nlp_pkg::ELEM_W'(n - k);
    end else if (kind < 14) begin
      // identity stays as built
    end else if (kind < 17) begin
      for (int k = 0; k < n; k++) begin
        perm_buf[k] = nlp_pkg::ELEM_W'($urandom_range(0, (1 << nlp_pkg::ELEM_W) - 1));
      end
    end else begin
      for (int k = 0; k < n; k++) perm_buf[k] = nlp_pkg::ELEM_W'($urandom_range(1, 3));
    end
  endfunction

  initial begin
    int unsigned n;
    int unsigned count;
    int unsigned sel;
    int unsigned phase_idx;
    logic [nlp_pkg::LEN_W-1:0] len;
    book             = new();
    requests         = 0;
    burst_left       = 0;
    length_writes    = 0;
    hold_reqs        = 0;
    rst_ni           = 1'b0;
    perm_length_we_i = 1'b0;
    perm_length_i    = '0;
    element_valid_i  = 1'b0;
    element_i        = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // --- directed ---
    // Reset length: last permutation of 16 wraps to the identity.
    for (int k = 0; k < nlp_pkg::MAX_LEN; k++) begin
      send_element(nlp_pkg::ELEM_W'(nlp_pkg::MAX_LEN - k));
    end
    // Length below range acts as 2; field extremes 0 and 31.
    write_length(nlp_pkg::LEN_W'(1));
    send_element(nlp_pkg::ELEM_W'(0));
    send_element(nlp_pkg::ELEM_W'(31));
    // Two-element last permutation wraps.
    write_length(nlp_pkg::LEN_W'(2));
    send_element(nlp_pkg::ELEM_W'(2));
    send_element(nlp_pkg::ELEM_W'(1));
    // Ordinary pivot, swap and suffix reverse.
    write_length(nlp_pkg::LEN_W'(3));
    send_element(nlp_pkg::ELEM_W'(1));
    send_element(nlp_pkg::ELEM_W'(3));
    send_element(nlp_pkg::ELEM_W'(2));
    // Length cut while a load is under way: the next request completes
    // the permutation from the first two stored elements (5,1 -> wrap).
    write_length(nlp_pkg::LEN_W'(4));
    send_element(nlp_pkg::ELEM_W'(5));
    send_element(nlp_pkg::ELEM_W'(1));
    send_element(nlp_pkg::ELEM_W'(4));
    write_length(nlp_pkg::LEN_W'(0));
    send_element(nlp_pkg::ELEM_W'(3));

    // --- random ---
    // Phase 0 is the back-pressure phase: short permutations offered
    // steadily while the receiver holds off. Phase 1 hits the top of the
    // register range. Later phases favor small lengths.
    phase_idx = 0;
    while (requests < TOTAL_ITEMS) begin
      if (phase_idx == 0) begin
        len = nlp_pkg::LEN_W'(3);
      end else if (phase_idx == 1) begin
        len = nlp_pkg::LEN_W'(31);
      end else begin
        sel = $urandom_range(0, 19);
        if (sel == 0) len = nlp_pkg::LEN_W'($urandom_range(0, 1));
        else if (sel == 1) len = nlp_pkg::LEN_W'($urandom_range(nlp_pkg::MAX_LEN + 1, 31));
        else if (sel < 4) len = nlp_pkg::LEN_W'(nlp_pkg::MAX_LEN);
        else len = nlp_pkg::LEN_W'($urandom_range(2, 6));
      end
      write_length(len);
      n = book.active_length();
      // Finish a load carried over from the previous length.
      while (book.fill != 0) begin
        send_element(nlp_pkg::ELEM_W'($urandom_range(0, (1 << nlp_pkg::ELEM_W) - 1)));
      end
      if (phase_idx == 0) begin
        hold_reqs++;
        count = 8;
      end else if (n >= nlp_pkg::MAX_LEN) begin
        count = $urandom_range(1, 2);
      end else begin
        count = $urandom_range(1, 5);
      end
      repeat (count) begin
        build_perm(n);
        for (int k = 0; k < n; k++) send_element(perm_buf[k]);
      end
      // Sometimes leave a partial load across the next length change.
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, n - 1)) send_element(nlp_pkg::ELEM_W'($urandom_range(1, n)));
      end
      phase_idx++;
    end
    while (book.fill != 0) send_element(nlp_pkg::ELEM_W'($urandom_range(1, n)));

    // --- drain ---
    @(negedge clk_i);
    element_valid_i <= 1'b0;
    while (book.expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("covered %0d requests in %0d permutations (%0d wrapped), %0d results checked",
             requests, book.perms, book.wraps, book.checked);
    $display("%0d length writes incl. 0, 1, 31 and a cut mid-load; one long output hold-off",
             length_writes);
    if (book.errors == 0 && book.expected_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
